// ===== sv/i2a_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Shared types and constants; no dependencies.
`default_nettype none

package i2a_pkg;

	localparam int unsigned ValueW    = 32;
	localparam int unsigned NumDigits = 10;
	localparam int unsigned StepW     = $clog2(ValueW);
	localparam int unsigned RemW      = $clog2(NumDigits + 1);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// controls broadcast to every digit cell
	typedef struct packed {
		logic clear;    // start a new conversion
		logic dabble;   // add-3 and shift one binary bit in
		logic shift_up; // move digits one place toward the top
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/i2a_cell.sv =====
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on i2a_pkg.
`default_nettype none

module i2a_cell
	import i2a_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      bit_in,    // carry from lower cell
	output logic           bit_out,   // carry to upper cell
	input  wire logic [3:0] digit_in, // digit of lower cell
	output logic [3:0]     digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add 3 when the digit would overflow after doubling
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.shift_up) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text.
// Depends on i2a_pkg and i2a_cell.
`default_nettype none

// Converts one signed 32-bit word to its decimal text, most significant
// character first. Pulse start while busy is low; value is sampled then.
// A negative word gives '-' on the cycle after start. The magnitude then
// passes bit by bit into a row of ten BCD digit cells (shift-and-add-3),
// one bit per cycle. Leading zero digits are dropped by shifting the row
// toward the top, one place each (up to 9). Each digit then leaves
// from the top cell, one per cycle, with strobe high for that cycle only.
// last marks the final character. The receiver cannot stall: every
// strobed word must be taken. busy is low again on the cycle that shows
// the final character.

module signed_int_to_decimal_ascii
	import i2a_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic signed [31:0] value,
	output logic                   strobe,
	output logic [7:0]             character,
	output logic                   last
);

	state_t state_q, state_d;

	logic [ValueW-1:0] mag_q;     // magnitude, shifted out MSB first
	logic [StepW-1:0]  step_q;    // binary bits consumed
	logic [RemW-1:0]   rem_q;     // digits left in the row
	logic              strobe_q;
	logic [7:0]        char_q;
	logic              last_q;

	cell_ctl_t ctl;
	logic      accept;
	logic      top_zero;
	logic      emit_now;
	logic      emit_last;

	logic [NumDigits:0]  carry;
	logic [3:0]          dig [NumDigits];
	logic [3:0]          dig_in [NumDigits];

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// ---------------- cell row ----------------
	assign carry[0] = mag_q[ValueW-1];

	genvar gi;
	generate
		for (gi = 0; gi < NumDigits; gi++) begin : g_cell
			if (gi == 0) begin : g_low
				assign dig_in[gi] = 4'd0;
			end else begin : g_up
				assign dig_in[gi] = dig[gi-1];
			end
			i2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.bit_in   (carry[gi]),
				.bit_out  (carry[gi+1]),
				.digit_in (dig_in[gi]),
				.digit    (dig[gi])
			);
		end
	endgenerate

	assign top_zero  = (dig[NumDigits-1] == 4'd0);
	assign emit_last = (rem_q == RemW'(1));

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (step_q == StepW'(ValueW - 1)) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!(top_zero && !emit_last)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- controls ----------------
	always_comb begin
		ctl      = '0;
		emit_now = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.clear = start;
			end
			ST_CONV: begin
				ctl.dabble = 1'b1;
			end
			ST_SKIP: begin
				ctl.shift_up = top_zero && !emit_last;
			end
			ST_EMIT: begin
				ctl.shift_up = 1'b1;
				emit_now     = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == ST_CONV) begin
				step_q <= step_q + StepW'(1);
			end
			if (state_q == ST_CONV && state_d == ST_SKIP) begin
				rem_q <= RemW'(NumDigits);
			end else if (ctl.shift_up) begin
				rem_q <= rem_q - RemW'(1);
			end
			// minus sign goes out first; accept and emit never coincide
			strobe_q <= accept ? value[ValueW-1] : emit_now;
		end
	end

	// payload: magnitude and output character
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= value[ValueW-1] ? ~value + 32'd1 : value;
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else begin
			if (state_q == ST_CONV) mag_q <= {mag_q[ValueW-2:0], 1'b0};
			if (emit_now) begin
				char_q <= ASCII_ZERO + {4'd0, dig[NumDigits-1]};
				last_q <= emit_last;
			end
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	// the top cell never overflows: ten digits hold any 32-bit magnitude
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dabble |-> !carry[NumDigits])
		else $error("digit row overflow");

	// final digit step produces a strobed last character
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_last) |=> (strobe && last))
		else $error("missing last character");

	// a minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == ASCII_MINUS) |-> !last)
		else $error("minus sign marked last");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// Testbench for signed_int_to_decimal_ascii: signed words in, decimal ASCII text out.
// Depends on i2a_pkg and the converter RTL.
`default_nettype none

module tb_signed_int_to_decimal_ascii;
	import i2a_pkg::*;

	// One character of expected text.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	localparam int unsigned RANDOM_WORDS = 135;
	// A word occupies the block until its final character. This limit is many
	// times the worst quiet stretch a correct run can show.
	localparam int unsigned STALL_LIMIT  = 1000;
	// Quiet time after the final character, a little over one word's occupancy.
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned MAX_REPORTS  = 10;

	// Directed words: zero, one digit, several decade boundaries, both range
	// ends, the most negative word (no positive twin), alternating bit patterns.
	localparam logic [31:0] CORNER_WORDS [25] = '{
		32'd0, 32'd1, -32'sd1, 32'd5, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
		-32'sd101, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd999999999,
		32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'd1234567890,
		-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE, 32'd1000,
		-32'sd99999, 32'd42
	};

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic signed [31:0] value  = '0;
	logic               busy;
	logic               strobe;
	logic [7:0]         character;
	logic               last;

	logic [31:0] pending_words [$]; // words not yet taken by the block
	text_char_t  expected_text [$]; // characters still owed by the block

	int unsigned total_words    = 0;
	int unsigned words_sent     = 0;
	int unsigned negative_words = 0;
	int unsigned chars_checked  = 0;
	int unsigned mismatches     = 0;
	int unsigned stall_cycles   = 0;
	int unsigned leftover       = 0;

	wire timed_out = (stall_cycles >= STALL_LIMIT);

	signed_int_to_decimal_ascii uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected text of one word: optional minus, then the magnitude's digits
	// with no leading zeros. The magnitude is taken unsigned, so the most
	// negative word maps to 2147483648 with no overflow.
	function automatic void predict_text(input logic [31:0] word);
		logic [31:0] mag;
		logic [3:0]  digits [NumDigits];
		int          nd;
		text_char_t  tc;
		mag = word[31] ? (~word + 32'd1) : word;
		nd  = 0;
		do begin
			digits[nd] = 4'(mag % 32'd10);
			mag        = mag / 32'd10;
			nd++;
		end while (mag != 0 && nd < NumDigits);
		if (word[31]) begin
			tc.ch   = ASCII_MINUS;
			tc.last = 1'b0;
			expected_text.push_back(tc);
		end
		for (int i = nd; i > 0; i--) begin
			tc.ch   = ASCII_ZERO + 8'(digits[i-1]);
			tc.last = (i == 1);
			expected_text.push_back(tc);
		end
	endfunction

	// Random word: a quarter raw 32-bit patterns, a quarter near zero, the
	// rest with a random digit count and sign so every text length shows up.
	function automatic logic [31:0] random_word();
		longint unsigned lo, hi, top;
		int unsigned     nd;
		logic            neg;
		logic [31:0]     mag;
		case ($urandom_range(0, 3))
			0: begin
				return $urandom();
			end
			1: begin
				return 32'($urandom_range(0, 20)) - 32'd10;
			end
			default: begin
				nd  = $urandom_range(1, NumDigits);
				neg = 1'($urandom_range(0, 1));
				lo  = 1;
				repeat (nd - 1) lo = lo * 10;
				hi  = lo * 10 - 1;
				top = neg ? 64'd2147483648 : 64'd2147483647;
				if (hi > top) hi = top;
				if (nd == 1) lo = 0;
				mag = $urandom_range(32'(hi), 32'(lo));
				return neg ? (~mag + 32'd1) : mag;
			end
		endcase
	endfunction

	// Sender idle rate by phase: light, heavy, then none.
	function automatic int unsigned sender_idle_pct();
		if (words_sent < total_words / 3)
			return 26;
		if (words_sent < (2 * total_words) / 3)
			return 76;
		return 0;
	endfunction

	// Driver: present the head of pending_words on start. A word is taken at
	// an edge with start high and busy low; it is predicted there and popped.
	// While start is high and the block is busy, start and value hold. Only one nonblocking
	// write per signal per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				predict_text(value);
				if (value[31])
					negative_words++;
				words_sent++;
				void'(pending_words.pop_front());
			end
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
				start <= 1'b1;
				value <= pending_words[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed word is taken on the edge that ends its cycle
	// and checked against the oldest expected character.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			chars_checked++;
			if (expected_text.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected character: got %0d (last %0b), none pending",
						character, last);
			end else begin
				want = expected_text.pop_front();
				if (character !== want.ch || last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("character %0d: expected %0d last %0b, got %0d last %0b",
							chars_checked, want.ch, want.last, character, last);
				end
			end
		end
	end

	// Watchdog: count edges where neither a word goes in nor a character comes out.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else if (!timed_out)
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		foreach (CORNER_WORDS[i])
			pending_words.push_back(CORNER_WORDS[i]);
		repeat (RANDOM_WORDS)
			pending_words.push_back(random_word());
		total_words = pending_words.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 && !timed_out)
			@(posedge clk);
		while (expected_text.size() != 0 && !timed_out)
			@(posedge clk);
		// Catch any stray character after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = expected_text.size();
		if (timed_out)
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
		if (leftover != 0)
			$display("%0d expected characters never arrived", leftover);
		$display("converted %0d words (%0d negative), checked %0d characters",
			words_sent, negative_words, chars_checked);
		$display("%0d mismatches; phases of light, heavy and no sender idling", mismatches);
		if (!timed_out && mismatches == 0 && leftover == 0)
			$display("signed_int_to_decimal_ascii: match");
		else
			$display("signed_int_to_decimal_ascii: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
